[hdl/sma_pkg.sv]
`timescale 1ns / 1ps

package sma_pkg;

    // Width of the window length register and of the result field.
    localparam int CFG_BITS = 9;
    localparam int AVG_BITS = 32;

    // Window length after reset.
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 9'd20;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // take the input beat, write it to the ring, seed the sum
        logic sum_step;  // read one older sample and accumulate
        logic div_init;  // load the divider from the finished sum
        logic div_step;  // one restoring division step
        logic load;      // move the signed quotient into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sum_done;  // all counted samples have been added
    } status_t;

endpackage

[hdl/sma_ram.sv]
`timescale 1ns / 1ps

module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/sma_datapath.sv]
`timescale 1ns / 1ps

module sma_datapath #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sma_pkg::cmd_t                       cmd,
    output sma_pkg::status_t                    status,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic                                restart,
    input  logic                                cfg_we,
    input  logic [sma_pkg::CFG_BITS-1:0]        cfg_data,
    output logic signed [sma_pkg::AVG_BITS-1:0] average
);

    localparam int SLOT_W   = $clog2(MAX_WINDOW);
    localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W    = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int EXT_W    = (CNT_W > sma_pkg::CFG_BITS) ? CNT_W : sma_pkg::CFG_BITS;
    localparam int OUT_KEEP = (SAMPLE_BITS < sma_pkg::AVG_BITS) ? SAMPLE_BITS
                                                                : sma_pkg::AVG_BITS;

    // Control registers.
    logic [sma_pkg::CFG_BITS-1:0] window_reg, window_next;
    logic [CNT_W-1:0]             fill_count_reg, fill_count_next;
    logic [SLOT_W-1:0]            write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]            rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]             remain_reg, remain_next;
    logic                         pend_reg, pend_next;

    // Payload registers.
    logic signed [SUM_W-1:0]      sum_reg, sum_next;
    logic [SUM_W-1:0]             q_reg, q_next;
    logic [CNT_W-1:0]             rem_reg, rem_next;
    logic [CNT_W-1:0]             divisor_reg, divisor_next;
    logic                         neg_reg, neg_next;
    logic signed [sma_pkg::AVG_BITS-1:0] average_reg, average_next;

    logic [EXT_W-1:0]             win_ext;
    logic [CNT_W-1:0]             eff_len;
    logic [SLOT_W-1:0]            base_slot;
    logic [CNT_W-1:0]             base_count;
    logic [CNT_W:0]               cnt_inc;
    logic [CNT_W-1:0]             new_count;
    logic                         ram_re;
    logic [SAMPLE_BITS-1:0]       ram_rdata;
    logic [SUM_W-1:0]             sum_mag;
    logic [CNT_W:0]               rem_shift;
    logic [CNT_W:0]               rem_diff;
    logic [SUM_W-1:0]             quot_signed;

    // Ring store of the most recent samples.
    sma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.start),
        .waddr (base_slot),
        .wdata (sample),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // Effective window: zero acts as one, large values saturate to the store depth.
    always_comb
    begin
        win_ext = EXT_W'(window_reg);
        if (win_ext == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (win_ext > EXT_W'(MAX_WINDOW))
        begin
            eff_len = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            eff_len = win_ext[CNT_W-1:0];
        end
    end

    // A restart begins the ring at slot zero with an empty count.
    always_comb
    begin
        base_slot  = restart ? '0 : write_slot_reg;
        base_count = restart ? '0 : fill_count_reg;
        cnt_inc    = {1'b0, base_count} + (CNT_W + 1)'(1);
        new_count  = (cnt_inc > {1'b0, eff_len}) ? eff_len : cnt_inc[CNT_W-1:0];
    end

    assign ram_re = cmd.sum_step && (remain_reg != '0);

    // Divider helpers.
    always_comb
    begin
        sum_mag     = sum_reg[SUM_W-1] ? (SUM_W'(0) - SUM_W'(sum_reg)) : SUM_W'(sum_reg);
        rem_shift   = {rem_reg, q_reg[SUM_W-1]};
        rem_diff    = rem_shift - {1'b0, divisor_reg};
        quot_signed = neg_reg ? (SUM_W'(0) - q_reg) : q_reg;
    end

    // Next-state logic of the datapath.
    always_comb
    begin
        window_next     = window_reg;
        fill_count_next = fill_count_reg;
        write_slot_next = write_slot_reg;
        rd_addr_next    = rd_addr_reg;
        remain_next     = remain_reg;
        pend_next       = pend_reg;
        sum_next        = sum_reg;
        q_next          = q_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        neg_next        = neg_reg;
        average_next    = average_reg;

        if (cfg_we)
        begin
            window_next = cfg_data;
        end

        // Take the beat: the new sample seeds the sum, older ones follow.
        if (cmd.start)
        begin
            fill_count_next = new_count;
            remain_next     = new_count - CNT_W'(1);
            sum_next        = SUM_W'(sample);
            pend_next       = 1'b0;
            rd_addr_next    = (base_slot == '0) ? SLOT_W'(MAX_WINDOW - 1)
                                                : base_slot - SLOT_W'(1);
            write_slot_next = (base_slot == SLOT_W'(MAX_WINDOW - 1)) ? '0
                                                : base_slot + SLOT_W'(1);
        end

        // Walk back through the ring, one read per cycle.
        if (cmd.sum_step)
        begin
            pend_next = ram_re;
            if (ram_re)
            begin
                remain_next  = remain_reg - CNT_W'(1);
                rd_addr_next = (rd_addr_reg == '0) ? SLOT_W'(MAX_WINDOW - 1)
                                                   : rd_addr_reg - SLOT_W'(1);
            end
            if (pend_reg)
            begin
                sum_next = sum_reg + SUM_W'($signed(ram_rdata));
            end
        end

        // Divide the magnitude; the sign is put back at the end.
        if (cmd.div_init)
        begin
            q_next       = sum_mag;
            rem_next     = '0;
            divisor_next = fill_count_reg;
            neg_next     = sum_reg[SUM_W-1];
        end

        if (cmd.div_step)
        begin
            if (rem_diff[CNT_W])
            begin
                rem_next = rem_shift[CNT_W-1:0];
                q_next   = {q_reg[SUM_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = rem_diff[CNT_W-1:0];
                q_next   = {q_reg[SUM_W-2:0], 1'b1};
            end
        end

        if (cmd.load)
        begin
            average_next = sma_pkg::AVG_BITS'(quot_signed[OUT_KEEP-1:0]);
        end
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= sma_pkg::WINDOW_RESET;
            fill_count_reg <= '0;
            write_slot_reg <= '0;
            rd_addr_reg    <= '0;
            remain_reg     <= '0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            window_reg     <= window_next;
            fill_count_reg <= fill_count_next;
            write_slot_reg <= write_slot_next;
            rd_addr_reg    <= rd_addr_next;
            remain_reg     <= remain_next;
            pend_reg       <= pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sum_reg     <= sum_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
        average_reg <= average_next;
    end

    assign status.sum_done = (remain_reg == '0) && !pend_reg;
    assign average         = average_reg;

endmodule

[hdl/sma_ctrl.sv]
`timescale 1ns / 1ps

module sma_ctrl #(
    parameter int DIV_STEPS = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output sma_pkg::cmd_t    cmd,
    input  sma_pkg::status_t status
);

    localparam int BIT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [BIT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    // The output register is free when empty or when its beat leaves now.
    assign out_free = !out_valid_reg || !out_stall;

    // Sequencing of one item.
    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        cmd            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (status.sum_done)
                begin
                    cmd.div_init = 1'b1;
                    bit_cnt_next = BIT_W'(DIV_STEPS - 1);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - BIT_W'(1);
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output valid is set by a load and cleared when its beat is taken.
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[hdl/simple_moving_average.sv]
`timescale 1ns / 1ps

// Simple moving average of signed Q16.16 samples: each input beat yields one
// output beat holding the mean of the last window_length samples (fewer during
// warm-up or right after a restart), truncated toward zero. The first step
// takes the beat and seeds the sum with the new sample. The older samples are
// then summed out of the single read port of the ring memory, one read per
// cycle, with no read when only the new sample counts. The one-bit-per-cycle
// restoring divider follows, and the mean then moves into the output register
// once that register is free, later if the previous result is still stalled
// there. A finished result waits in the output register, so the next input
// beat is taken while it is still stalled. The window length register may be
// written at any time the block is idle; cfg_ready is always high.
module simple_moving_average #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sma_pkg::AVG_BITS-1:0] average,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sma_pkg::CFG_BITS-1:0]        cfg_data
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);

    sma_pkg::cmd_t    cmd;
    sma_pkg::status_t status;

    assign cfg_ready = 1'b1;

    // Sequencer for the summing and division phases.
    sma_ctrl #(
        .DIV_STEPS (SUM_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // Ring memory, accumulator and divider.
    sma_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .sample   (sample),
        .restart  (restart),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .average  (average)
    );

endmodule

[hdl/sma_checker.sv]
`timescale 1ns / 1ps

module sma_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [sma_pkg::AVG_BITS-1:0] average
);

    logic       in_beat;
    logic       out_beat;
    logic [1:0] pending_reg, pending_next;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;

    // Items taken in whose result beat has not left yet.
    always_comb
    begin
        pending_next = pending_reg + 2'(in_beat) - 2'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result stays and holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(average))
        else $error("stalled result changed or dropped");

    // No result beat without an item to answer for.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result beat without an outstanding item");

    // At most one item at work and one result waiting.
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 2'd2)
        else $error("too many outstanding items");

    // Once an item is taken, the block is busy with it.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> in_stall)
        else $error("input taken again while the previous item is at work");

endmodule

bind simple_moving_average sma_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .average   (average)
);
